// File: rtl/jai_pkg.sv
`timescale 1ns / 1ps

package jai_pkg;

   // item kinds
   localparam logic KIND_ANGLE  = 1'b0;
   localparam logic KIND_LENGTH = 1'b1;

   // a full turn is 360 degrees = 45 * 2^3, half a turn 180 degrees
   localparam int unsigned TURN_DEG   = 360;
   localparam int unsigned HALF_DEG   = 180;
   localparam int unsigned TURN_SLICE = 45;
   localparam int unsigned SLICE_BITS = 3;
   localparam int unsigned MOD_W      = 6;

   // load enables of the two stages inside the turn reduction
   typedef struct packed {
      logic load_a;
      logic load_b;
   } stage_en_type;

endpackage

// File: rtl/jai_turn_reduce.sv
`timescale 1ns / 1ps

// two stage reduction of a signed value into [0, 360 << ANGLE_FRAC_BITS)
module jai_turn_reduce #(
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  logic                               clock,
   input  jai_pkg::stage_en_type              en,
   input  logic [31:0]                        value,
   output logic [jai_pkg::MOD_W+ANGLE_FRAC_BITS+jai_pkg::SLICE_BITS-1:0] wrapped
);

   localparam int SH     = ANGLE_FRAC_BITS + jai_pkg::SLICE_BITS;
   localparam int W      = 32 - SH;
   localparam int RS     = W + 6;
   localparam int TURN_W = jai_pkg::MOD_W + SH;

   // reciprocal of 45, exact for every W bit operand
   localparam logic [63:0] MUL_WIDE =
      ((64'd1 << RS) + 64'(jai_pkg::TURN_SLICE - 1)) / 64'(jai_pkg::TURN_SLICE);
   localparam logic [W:0] MUL = MUL_WIDE[W:0];

   // value = 2^(W-1) mod 45 has to come back out after the unsigned bias
   localparam logic [63:0] BIAS_MOD = (64'd1 << (W - 1)) % 64'(jai_pkg::TURN_SLICE);
   localparam logic [6:0] OFF =
      7'((64'(jai_pkg::TURN_SLICE) - BIAS_MOD) % 64'(jai_pkg::TURN_SLICE));
   localparam logic [6:0] SLICE7 = 7'(jai_pkg::TURN_SLICE);

   logic [W-1:0]    q_biased;
   logic [2*W:0]    prod_in;
   logic [2*W:0]    prod_ff;
   logic [6:0]      u_low_ff;
   logic [SH-1:0]   frac_ff;

   logic [W-RS+W:0] quot;
   logic [6:0]      r_raw;
   logic [6:0]      r_fix;
   logic [6:0]      m_raw;
   logic [6:0]      m_fix;
   logic [TURN_W-1:0] wrapped_in;
   logic [TURN_W-1:0] wrapped_ff;

   // floor(value / 2^SH) with the sign bit flipped is an unsigned offset
   always_comb begin
      q_biased = {~value[31], value[30:SH]};
      prod_in  = (2*W+1)'(q_biased) * (2*W+1)'(MUL);
   end

   always_ff @(posedge clock) begin
      if (en.load_a) begin
         prod_ff  <= prod_in;
         u_low_ff <= q_biased[6:0];
         frac_ff  <= value[SH-1:0];
      end
      if (en.load_b) begin
         wrapped_ff <= wrapped_in;
      end
   end

   // remainder only needs the low 7 bits since it stays below 128
   always_comb begin
      quot  = prod_ff[2*W:RS];
      r_raw = u_low_ff - 7'(quot[6:0] * SLICE7);
      r_fix = (r_raw >= SLICE7) ? r_raw - SLICE7 : r_raw;
      m_raw = r_fix + OFF;
      m_fix = (m_raw >= SLICE7) ? m_raw - SLICE7 : m_raw;
      wrapped_in = {m_fix[jai_pkg::MOD_W-1:0], frac_ff};
   end

   assign wrapped = wrapped_ff;

endmodule

// File: rtl/joint_angle_interpolator_core.sv
`timescale 1ns / 1ps

// Interpolates one joint per item between two key frame values at fraction t.
// req channel: kind (0 angle, 1 length), start and end value in signed fixed
// point, fraction t in Q1.FRACTION_BITS (values above one act as one).
// rsp channel: one blended value per item, in the order the items came in.
// Angles come back wrapped into [0, 360 << ANGLE_FRAC_BITS).
// Six register stages: input register, two turn reduction stages,
// difference, multiply, sum. Throughput: one item per cycle while
// rsp_stall is low. Each stage has its own valid bit, so bubbles close
// up while rsp_stall is high; req_stall rises only once all six stages
// hold an item. A stalled result holds in the output register until its
// transfer. Reset clears all valid bits; no item is in flight afterwards.
module joint_angle_interpolator_core #(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int FRACTION_BITS   = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_kind,
   input  logic signed [31:0]       req_start_value,
   input  logic signed [31:0]       req_end_value,
   input  logic [FRACTION_BITS:0]   req_fraction,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_blended_value
);

   localparam int NS     = 6;
   localparam int FB     = FRACTION_BITS;
   localparam int TURN_W = jai_pkg::MOD_W + ANGLE_FRAC_BITS + jai_pkg::SLICE_BITS;
   localparam logic [FB:0] T_ONE = {1'b1, {FB{1'b0}}};
   localparam logic signed [TURN_W:0] FULL_D =
      (TURN_W+1)'(jai_pkg::TURN_DEG << ANGLE_FRAC_BITS);
   localparam logic signed [TURN_W:0] HALF_D =
      (TURN_W+1)'(jai_pkg::HALF_DEG << ANGLE_FRAC_BITS);
   localparam logic signed [33:0] FULL_S = 34'(jai_pkg::TURN_DEG << ANGLE_FRAC_BITS);

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS-1:0] en;

   // stage payloads
   logic               s0_kind_ff;
   logic signed [31:0] s0_start_ff;
   logic signed [31:0] s0_end_ff;
   logic [FB:0]        s0_t_ff;
   logic [FB:0]        s0_t_in;
   logic               s1_kind_ff;
   logic signed [31:0] s1_start_ff;
   logic signed [31:0] s1_end_ff;
   logic [FB:0]        s1_t_ff;
   logic               s2_kind_ff;
   logic signed [31:0] s2_start_ff;
   logic signed [31:0] s2_end_ff;
   logic [FB:0]        s2_t_ff;
   logic [TURN_W-1:0]  ws;
   logic [TURN_W-1:0]  we;
   logic signed [TURN_W:0] d_ang;
   logic signed [TURN_W:0] d_fold;
   logic signed [32:0] s3_d_in;
   logic signed [31:0] s3_base_in;
   logic               s3_kind_ff;
   logic signed [32:0] s3_d_ff;
   logic signed [31:0] s3_base_ff;
   logic [FB:0]        s3_t_ff;
   logic signed [FB+34:0] s4_prod_in;
   logic signed [FB+34:0] s4_prod_ff;
   logic               s4_kind_ff;
   logic signed [31:0] s4_base_ff;
   logic signed [32:0] delta;
   logic signed [33:0] sum;
   logic signed [31:0] s5_result_in;
   logic               s5_kind_ff;
   logic signed [31:0] s5_result_ff;
   jai_pkg::stage_en_type start_en;
   jai_pkg::stage_en_type end_en;

   // a stage loads when it is empty or its successor moves on
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[NS-1];
   assign rsp_blended_value = s5_result_ff;

   assign s0_t_in = (req_fraction > T_ONE) ? T_ONE : req_fraction;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_kind_ff  <= req_kind;
         s0_start_ff <= req_start_value;
         s0_end_ff   <= req_end_value;
         s0_t_ff     <= s0_t_in;
      end
      if (en[1]) begin
         s1_kind_ff  <= s0_kind_ff;
         s1_start_ff <= s0_start_ff;
         s1_end_ff   <= s0_end_ff;
         s1_t_ff     <= s0_t_ff;
      end
      if (en[2]) begin
         s2_kind_ff  <= s1_kind_ff;
         s2_start_ff <= s1_start_ff;
         s2_end_ff   <= s1_end_ff;
         s2_t_ff     <= s1_t_ff;
      end
      if (en[3]) begin
         s3_kind_ff <= s2_kind_ff;
         s3_d_ff    <= s3_d_in;
         s3_base_ff <= s3_base_in;
         s3_t_ff    <= s2_t_ff;
      end
      if (en[4]) begin
         s4_kind_ff <= s3_kind_ff;
         s4_prod_ff <= s4_prod_in;
         s4_base_ff <= s3_base_ff;
      end
      if (en[5]) begin
         s5_kind_ff   <= s4_kind_ff;
         s5_result_ff <= s5_result_in;
      end
   end

   assign start_en = '{load_a: en[1], load_b: en[2]};
   assign end_en   = '{load_a: en[1], load_b: en[2]};

   jai_turn_reduce #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_start_reduce (
      .clock  (clock),
      .en     (start_en),
      .value  (s0_start_ff),
      .wrapped(ws)
   );

   jai_turn_reduce #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_end_reduce (
      .clock  (clock),
      .en     (end_en),
      .value  (s0_end_ff),
      .wrapped(we)
   );

   // shorter way round; exactly half a turn stays as it is
   always_comb begin
      d_ang = $signed({1'b0, we}) - $signed({1'b0, ws});
      if (d_ang > HALF_D) begin
         d_fold = d_ang - FULL_D;
      end else if (d_ang < -HALF_D) begin
         d_fold = d_ang + FULL_D;
      end else begin
         d_fold = d_ang;
      end
      if (s2_kind_ff == jai_pkg::KIND_LENGTH) begin
         // (1-t)*s + t*e == s + t*(e-s), floor unchanged
         s3_d_in    = 33'(s2_end_ff) - 33'(s2_start_ff);
         s3_base_in = s2_start_ff;
      end else begin
         s3_d_in    = 33'(d_fold);
         s3_base_in = 32'({1'b0, ws});
      end
   end

   assign s4_prod_in = $signed({1'b0, s3_t_ff}) * s3_d_ff;

   // arithmetic shift gives the floor of the scaled product
   always_comb begin
      delta = s4_prod_ff[FB+32:FB];
      sum   = {{2{s4_base_ff[31]}}, s4_base_ff} + {delta[32], delta};
      if (s4_kind_ff == jai_pkg::KIND_LENGTH) begin
         s5_result_in = sum[31:0];
      end else if (sum < 34'sd0) begin
         s5_result_in = 32'(sum + FULL_S);
      end else if (sum >= FULL_S) begin
         s5_result_in = 32'(sum - FULL_S);
      end else begin
         s5_result_in = sum[31:0];
      end
   end

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && s5_kind_ff == jai_pkg::KIND_ANGLE)
      |-> ($unsigned(rsp_blended_value) < $unsigned(32'(FULL_S))))
      else $error("angle result outside one turn");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v_ff == {NS{1'b1}}))
      else $error("req stalled with a bubble in the pipeline");

   a_t_clamped: assert property (@(posedge clock) disable iff (reset)
      v_ff[3] |-> (s3_t_ff <= T_ONE))
      else $error("fraction above one reached the multiplier");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int ANGLE_FRAC_BITS = 8;
   localparam int FRACTION_BITS   = 16;
   localparam longint FULL_TURN   = longint'(jai_pkg::TURN_DEG) << ANGLE_FRAC_BITS;
   localparam longint HALF_TURN   = longint'(jai_pkg::HALF_DEG) << ANGLE_FRAC_BITS;
   localparam longint T_ONE       = longint'(1) << FRACTION_BITS;
   localparam int T_ONE_INT       = 1 << FRACTION_BITS;
   localparam int FRAC_MAX        = (1 << (FRACTION_BITS + 1)) - 1;
   localparam int RANDOM_JOINTS   = 450;
   localparam int CALM_TAIL       = 50;
   localparam int HOLD_CYCLES     = 40;
   localparam int SETTLE_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT  = 2000;

   typedef struct {
      logic                     kind;
      logic signed [31:0]       start_value;
      logic signed [31:0]       end_value;
      logic [FRACTION_BITS:0]   fraction;
      bit                       drain_first;
   } joint_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_kind = jai_pkg::KIND_ANGLE;
   logic signed [31:0]       req_start_value = '0;
   logic signed [31:0]       req_end_value = '0;
   logic [FRACTION_BITS:0]   req_fraction = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [31:0]       rsp_blended_value;

   joint_type          pending_joints[$];
   logic signed [31:0] expected_blends[$];
   bit                 req_done = 1'b0;
   int                 send_gap = 0;
   int                 recv_gap = 0;
   int                 hold_left = 0;
   bit                 hold_done = 1'b0;
   int                 rsp_count = 0;
   int                 quiet_cycles = 0;
   int                 errors = 0;

   joint_angle_interpolator_core #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_start_value(req_start_value),
      .req_end_value(req_end_value),
      .req_fraction(req_fraction),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_blended_value(rsp_blended_value)
   );

   always #2 clock = ~clock;

   function automatic longint wrap_turn(input longint v);
      longint m;
      m = v % FULL_TURN;
      if (m < 0) begin
         m = m + FULL_TURN;
      end
      return m;
   endfunction

   function automatic logic signed [31:0] blend_joint(input logic kind,
                                                      input logic signed [31:0] start_value,
                                                      input logic signed [31:0] end_value,
                                                      input logic [FRACTION_BITS:0] fraction);
      longint t;
      longint s;
      longint e;
      longint d;
      longint r;
      t = longint'(fraction);
      s = longint'(start_value);
      e = longint'(end_value);
      if (t > T_ONE) begin
         t = T_ONE;
      end
      if (kind == jai_pkg::KIND_LENGTH) begin
         // arithmetic shift of a signed sum floors toward minus infinity
         r = ((T_ONE - t) * s + t * e) >>> FRACTION_BITS;
      end else begin
         s = wrap_turn(s);
         e = wrap_turn(e);
         d = e - s;
         // shorter way round; exactly half a turn stays as it is
         if (d > HALF_TURN) begin
            d = d - FULL_TURN;
         end else if (d < -HALF_TURN) begin
            d = d + FULL_TURN;
         end
         r = wrap_turn(s + ((t * d) >>> FRACTION_BITS));
      end
      return r[31:0];
   endfunction

   task automatic add_joint(input logic kind, input logic signed [31:0] start_value,
                            input logic signed [31:0] end_value, input int fraction,
                            input bit drain_first);
      joint_type j;
      j.kind        = kind;
      j.start_value = start_value;
      j.end_value   = end_value;
      j.fraction    = fraction[FRACTION_BITS:0];
      j.drain_first = drain_first;
      pending_joints.push_back(j);
   endtask

   function automatic logic signed [31:0] random_value();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = int'($urandom_range(0, int'(6 * FULL_TURN))) - int'(3 * FULL_TURN);
         4, 5, 6: v = $urandom;
         7: begin
            if ($urandom_range(0, 1) == 0) begin
               v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            end else begin
               v = 32'h8000_0000 + $urandom_range(0, 3);
            end
         end
         default: v = int'($urandom_range(0, int'(FULL_TURN) - 1));
      endcase
      return v;
   endfunction

   function automatic int random_fraction();
      int f;
      case ($urandom_range(0, 19))
         0, 1, 2: f = int'($urandom_range(0, FRAC_MAX));
         3: f = 0;
         4: f = T_ONE_INT;
         5: f = T_ONE_INT - 1;
         default: f = int'($urandom_range(0, T_ONE_INT));
      endcase
      return f;
   endfunction

   // sender: one decision per falling edge, payload held until its transfer
   always @(negedge clock) begin : drive_req
      joint_type j;
      bit        offer;
      bit        calm;
      offer = 1'b0;
      calm  = pending_joints.size() < CALM_TAIL;
      if (!reset && (req_done || !req_valid)) begin
         req_done = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_joints.size() > 0) begin
            if (pending_joints[0].drain_first && expected_blends.size() != 0) begin
               offer = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 4);
            end else begin
               j = pending_joints.pop_front();
               offer = 1'b1;
            end
         end
         req_valid <= offer;
         if (offer) begin
            req_kind        <= j.kind;
            req_start_value <= j.start_value;
            req_end_value   <= j.end_value;
            req_fraction    <= j.fraction;
         end
      end
   end

   // receiver: random stall bursts plus one long hold-off to back up the pipe
   always @(negedge clock) begin : drive_rsp
      bit stall_next;
      bit calm;
      calm = pending_joints.size() < CALM_TAIL;
      stall_next = 1'b0;
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (!hold_done && rsp_count >= 120) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            stall_next = 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            stall_next = 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 4);
            stall_next = 1'b1;
         end
      end
      rsp_stall <= stall_next;
   end

   always @(posedge clock) begin : monitor
      bit                 moved;
      logic signed [31:0] want;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_blends.push_back(blend_joint(req_kind, req_start_value,
                                                  req_end_value, req_fraction));
            req_done = 1'b1;
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            rsp_count++;
            if (expected_blends.size() == 0) begin
               $display("%0t: unexpected transfer, blended_value %0d", $time,
                        rsp_blended_value);
               errors++;
            end else begin
               want = expected_blends.pop_front();
               if (rsp_blended_value !== want) begin
                  $display("%0t: blended_value expected %0d actual %0d", $time, want,
                           rsp_blended_value);
                  errors++;
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      logic               kind;
      logic signed [31:0] s;
      logic signed [31:0] e;
      longint             step;

      // fold boundaries, wrap of negative and huge angles, clamping of t, length extremes
      add_joint(jai_pkg::KIND_ANGLE, 0, 0, 0, 0);
      add_joint(jai_pkg::KIND_ANGLE, 0, 46080, 32768, 0);
      add_joint(jai_pkg::KIND_ANGLE, 0, 46081, 32768, 0);
      add_joint(jai_pkg::KIND_ANGLE, 46081, 0, 32768, 0);
      add_joint(jai_pkg::KIND_ANGLE, 46080, 0, T_ONE_INT, 0);
      add_joint(jai_pkg::KIND_ANGLE, -1, 1, T_ONE_INT, 0);
      add_joint(jai_pkg::KIND_ANGLE, 32'h8000_0000, 32'h7FFF_FFFF, T_ONE_INT - 1, 0);
      add_joint(jai_pkg::KIND_ANGLE, 32'h7FFF_FFFF, 32'h8000_0000, FRAC_MAX, 0);
      add_joint(jai_pkg::KIND_ANGLE, 92160 * 5 + 100, -92160 * 3 - 100, T_ONE_INT + 1, 0);
      add_joint(jai_pkg::KIND_ANGLE, 350 * 256, 10 * 256, 32768, 0);
      add_joint(jai_pkg::KIND_ANGLE, 10 * 256, 350 * 256, 1, 0);
      add_joint(jai_pkg::KIND_ANGLE, 92159, 0, T_ONE_INT - 1, 0);
      add_joint(jai_pkg::KIND_LENGTH, 32'h8000_0000, 32'h7FFF_FFFF, 32768, 0);
      add_joint(jai_pkg::KIND_LENGTH, 32'h7FFF_FFFF, 32'h8000_0000, FRAC_MAX, 0);
      add_joint(jai_pkg::KIND_LENGTH, 32'h8000_0000, 32'h8000_0000, T_ONE_INT, 0);
      add_joint(jai_pkg::KIND_LENGTH, -100, 100, 1, 0);
      add_joint(jai_pkg::KIND_LENGTH, 0, -1, T_ONE_INT - 1, 0);
      add_joint(jai_pkg::KIND_LENGTH, 5, 7, 0, 0);
      add_joint(jai_pkg::KIND_LENGTH, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 98304, 0);
      add_joint(jai_pkg::KIND_LENGTH, 123456, -654321, T_ONE_INT, 0);

      for (int i = 0; i < RANDOM_JOINTS; i++) begin
         kind = 1'($urandom_range(0, 1));
         s = random_value();
         e = random_value();
         if (kind == jai_pkg::KIND_ANGLE && $urandom_range(0, 5) == 0) begin
            // land right on or next to half a turn apart
            step = HALF_TURN + longint'($urandom_range(0, 2)) - 1;
            e = ($urandom_range(0, 1) == 0) ? s + int'(step) : s - int'(step);
         end
         add_joint(kind, s, e, random_fraction(), i == 200 || i == 350);
      end

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      while (pending_joints.size() != 0 || req_valid || expected_blends.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/jai_pkg.sv
rtl/jai_turn_reduce.sv
rtl/joint_angle_interpolator_core.sv
test/testbench.sv
